### rtl/core/ppia_pkg.sv
// Shared constants, register codes and types of the point-to-pillar index unit.
package ppia_pkg;

	localparam int MAP_DEPTH   = 65536;
	localparam int ADDR_W      = $clog2(MAP_DEPTH);
	localparam int COORD_W     = 20;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int INV_W       = 24;
	localparam int PROD_W      = DIFF_W + INV_W + 1;
	localparam int FRAC_W      = 24;
	localparam int GRID_W      = 11;
	localparam int CELL_FULL_W = 2 * GRID_W + 1;
	localparam int IDX_OUT_W   = 16;
	localparam int PILLAR_W    = 16;
	localparam int COUNT_W     = 17;
	localparam int EPOCH_W     = 8;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(65536);
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_X        = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y        = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Z        = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_Z_LIMIT      = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_INV_SIZE_X   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_INV_SIZE_Y   = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = CFG_IDX_W'(7);

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] z_limit;
		logic [INV_W-1:0]          inv_size_x;
		logic [INV_W-1:0]          inv_size_y;
		logic [GRID_W-1:0]         grid_columns;
		logic [GRID_W-1:0]         grid_rows;
	} cfg_regs_t;

	typedef struct packed {
		logic              valid;
		logic              kind;
		logic              ok;
		logic [ADDR_W-1:0] addr;
	} cell_req_t;

	typedef struct packed {
		logic [EPOCH_W-1:0]  epoch;
		logic [PILLAR_W-1:0] pillar;
	} map_entry_t;

	typedef struct packed {
		logic                 in_range;
		logic                 is_new;
		logic [IDX_OUT_W-1:0] cell_index;
		logic [PILLAR_W-1:0]  pillar_index;
		logic [COUNT_W-1:0]   pillar_count;
	} result_t;

endpackage

### rtl/core/ppia_if.sv
// Point, result and configuration channel interfaces.
interface ppia_point_if;
	import ppia_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	modport source (output valid, kind, point_x, point_y, point_z, input ready);
	modport sink (input valid, kind, point_x, point_y, point_z, output ready);
endinterface

interface ppia_result_if;
	import ppia_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 in_range;
	logic                 is_new;
	logic [IDX_OUT_W-1:0] cell_index;
	logic [PILLAR_W-1:0]  pillar_index;
	logic [COUNT_W-1:0]   pillar_count;
	modport source (output valid, in_range, is_new, cell_index, pillar_index, pillar_count,
		input ready);
	modport sink (input valid, in_range, is_new, cell_index, pillar_index, pillar_count,
		output ready);
endinterface

interface ppia_cfg_if;
	import ppia_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/point_to_pillar_index_assign_unit.sv
// Point-to-pillar index assignment: grid mapping, cell map read-modify-write, result register.
// Stages s1, s2 (calc), s3 (map read), result; one word per cycle unless stalled or clearing.
// The rate is set by the single cell map read port, with write-to-read forwarding.
// Output stall holds the whole pipeline. Frame start bumps an epoch tag kept per map entry.
// Reset: config defaults, then a pass clearing all MAP_DEPTH (65536) entries with input held off.
// The same clearing pass runs on every frame start that wraps the 8-bit epoch (every 255 frames).
module point_to_pillar_index_assign_unit (
	input  logic          clk,
	input  logic          arst_n,
	ppia_point_if.sink    pts,
	ppia_result_if.source res,
	ppia_cfg_if.sink      cfg
);
	import ppia_pkg::*;

	cfg_regs_t           regs_q;
	cell_req_t           req_s2;
	cell_req_t           req_s3;
	map_entry_t          map_mem [MAP_DEPTH];
	map_entry_t          mem_rd_q;
	logic                fwd_valid_q;
	logic [ADDR_W-1:0]   fwd_addr_q;
	map_entry_t          fwd_data_q;
	logic                ignore_rd_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic [COUNT_W-1:0]  count_q;
	logic                clear_busy_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                out_valid_q;
	result_t             out_q;

	logic                adv;
	logic                fwd_hit;
	map_entry_t          cur;
	logic                seen;
	logic                is_point;
	logic                is_frame;
	logic                start_clear;
	logic                mem_we;
	map_entry_t          wdata;
	logic [COUNT_W-1:0]  count_d;
	result_t             res_d;

	assign adv       = !clear_busy_q && (!out_valid_q || res.ready);
	assign pts.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_x        <= '0;
			regs_q.min_y        <= '0;
			regs_q.min_z        <= '0;
			regs_q.z_limit      <= '0;
			regs_q.inv_size_x   <= INV_W'(65536);
			regs_q.inv_size_y   <= INV_W'(65536);
			regs_q.grid_columns <= GRID_W'(200);
			regs_q.grid_rows    <= GRID_W'(200);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MIN_X:        regs_q.min_x        <= cfg.data[COORD_W-1:0];
				REG_MIN_Y:        regs_q.min_y        <= cfg.data[COORD_W-1:0];
				REG_MIN_Z:        regs_q.min_z        <= cfg.data[COORD_W-1:0];
				REG_Z_LIMIT:      regs_q.z_limit      <= cfg.data[COORD_W-1:0];
				REG_INV_SIZE_X:   regs_q.inv_size_x   <= cfg.data[INV_W-1:0];
				REG_INV_SIZE_Y:   regs_q.inv_size_y   <= cfg.data[INV_W-1:0];
				REG_GRID_COLUMNS: regs_q.grid_columns <= cfg.data[GRID_W-1:0];
				REG_GRID_ROWS:    regs_q.grid_rows    <= cfg.data[GRID_W-1:0];
				default: ;
			endcase
		end
	end

	ppia_cell_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (pts.valid),
		.in_kind  (pts.kind),
		.point_x  (pts.point_x),
		.point_y  (pts.point_y),
		.point_z  (pts.point_z),
		.regs     (regs_q),
		.req_s2   (req_s2)
	);

	// entry written on the edge that read this word comes from the forward register
	assign fwd_hit  = fwd_valid_q && (fwd_addr_q == req_s3.addr);
	assign cur      = fwd_hit ? fwd_data_q : mem_rd_q;
	assign seen     = !ignore_rd_q && (cur.epoch == epoch_q);
	assign is_point = req_s3.valid && (req_s3.kind == KIND_POINT);
	assign is_frame = req_s3.valid && (req_s3.kind == KIND_FRAME);
	assign start_clear = is_frame && (epoch_q == EPOCH_LAST);
	assign wdata.epoch  = epoch_q;
	assign wdata.pillar = count_q[PILLAR_W-1:0];

	always_comb begin
		res_d   = '0;
		count_d = count_q;
		mem_we  = 1'b0;
		if (is_frame) begin
			count_d = '0;
		end else if (is_point && req_s3.ok) begin
			res_d.in_range   = 1'b1;
			res_d.cell_index = IDX_OUT_W'(req_s3.addr);
			if (seen) begin
				res_d.pillar_index = cur.pillar;
			end else if (count_q < COUNT_MAX) begin
				res_d.is_new       = 1'b1;
				res_d.pillar_index = count_q[PILLAR_W-1:0];
				count_d            = count_q + COUNT_W'(1);
				mem_we             = adv;
			end
		end
		res_d.pillar_count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s3       <= '0;
			fwd_valid_q  <= 1'b0;
			ignore_rd_q  <= 1'b0;
			epoch_q      <= EPOCH_FIRST;
			count_q      <= '0;
			clear_busy_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clear_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(MAP_DEPTH - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end else if (adv) begin
			req_s3      <= req_s2;
			fwd_valid_q <= mem_we;
			// word read before a clearing pass is stale
			ignore_rd_q <= start_clear;
			count_q     <= count_d;
			if (is_frame) begin
				epoch_q <= start_clear ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
			end
			if (start_clear) begin
				clear_busy_q <= 1'b1;
				clr_addr_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= req_s3.valid;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q      <= res_d;
			fwd_addr_q <= req_s3.addr;
			fwd_data_q <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (clear_busy_q) begin
			map_mem[clr_addr_q] <= '0;
		end else if (mem_we) begin
			map_mem[req_s3.addr] <= wdata;
		end
		if (adv) begin
			mem_rd_q <= map_mem[req_s2.addr];
		end
	end

	assign res.valid        = out_valid_q;
	assign res.in_range     = out_q.in_range;
	assign res.is_new       = out_q.is_new;
	assign res.cell_index   = out_q.cell_index;
	assign res.pillar_index = out_q.pillar_index;
	assign res.pillar_count = out_q.pillar_count;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy_q |-> !pts.ready)
		else $error("point accepted during map clearing pass");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("pillar count beyond its maximum");

	a_new_pillar_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> count_q == COUNT_W'($past(count_q) + COUNT_W'(1)))
		else $error("new pillar written without count advance");

	a_wrap_starts_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start_clear && adv) |=> (clear_busy_q && ignore_rd_q && epoch_q == EPOCH_FIRST))
		else $error("epoch wrap did not start a clearing pass");

endmodule

### rtl/core/ppia_cell_calc.sv
// Two-stage grid mapping: scaled offsets, then range checks and flat cell address.
module ppia_cell_calc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic                               in_kind,
	input  logic signed [ppia_pkg::COORD_W-1:0] point_x,
	input  logic signed [ppia_pkg::COORD_W-1:0] point_y,
	input  logic signed [ppia_pkg::COORD_W-1:0] point_z,
	input  ppia_pkg::cfg_regs_t                regs,
	output ppia_pkg::cell_req_t                req_s2
);
	import ppia_pkg::*;

	logic signed [DIFF_W-1:0] diff_x;
	logic signed [DIFF_W-1:0] diff_y;
	logic                     valid_s1;
	logic                     kind_s1;
	logic                     z_ok_s1;
	logic signed [PROD_W-1:0] prod_x_s1;
	logic signed [PROD_W-1:0] prod_y_s1;

	logic [PROD_W-FRAC_W-2:0] col;
	logic [PROD_W-FRAC_W-2:0] row;
	logic                     col_ok;
	logic                     row_ok;
	logic [CELL_FULL_W-1:0]   cell_full;
	logic                     in_map;

	assign diff_x = DIFF_W'(point_x) - DIFF_W'(regs.min_x);
	assign diff_y = DIFF_W'(point_y) - DIFF_W'(regs.min_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1   <= in_kind;
			z_ok_s1   <= (point_z >= regs.min_z) && (point_z < regs.z_limit);
			prod_x_s1 <= diff_x * $signed({1'b0, regs.inv_size_x});
			prod_y_s1 <= diff_y * $signed({1'b0, regs.inv_size_y});
		end
	end

	// sign bit set means the floored index is negative
	assign col    = prod_x_s1[PROD_W-2:FRAC_W];
	assign row    = prod_y_s1[PROD_W-2:FRAC_W];
	assign col_ok = !prod_x_s1[PROD_W-1] && (col < (PROD_W-FRAC_W-1)'(regs.grid_columns));
	assign row_ok = !prod_y_s1[PROD_W-1] && (row < (PROD_W-FRAC_W-1)'(regs.grid_rows));

	assign cell_full = CELL_FULL_W'(row[GRID_W-1:0]) * CELL_FULL_W'(regs.grid_columns)
		+ CELL_FULL_W'(col[GRID_W-1:0]);
	assign in_map = cell_full < CELL_FULL_W'(MAP_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s2 <= '0;
		end else if (adv) begin
			req_s2.valid <= valid_s1;
			req_s2.kind  <= kind_s1;
			req_s2.ok    <= col_ok && row_ok && z_ok_s1 && in_map;
			req_s2.addr  <= cell_full[ADDR_W-1:0];
		end
	end

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the point-to-pillar index unit: random and directed lidar words, scoreboard.
`timescale 1ns / 1ps

module tb_top;
	import ppia_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 12;
	localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);

	typedef struct {
		logic                      kind;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} lidar_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ppia_point_if  pts_ch ();
	ppia_result_if res_ch ();
	ppia_cfg_if    cfg_ch ();

	point_to_pillar_index_assign_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the grid setup, changed only while the unit is idle
	logic signed [COORD_W-1:0] org_x, org_y, z_floor, z_lim;
	logic [INV_W-1:0]          recip_x, recip_y;
	logic [GRID_W-1:0]         grid_cols, grid_rows;

	logic [PILLAR_W-1:0] pillar_of_cell [int];
	logic [COUNT_W-1:0]  pillars_opened;

	lidar_word_t point_words [$];
	result_t     pillar_results_due [$];
	lidar_word_t on_wire;
	int          send_hold, recv_hold;
	bit          steady;
	int          mismatches;
	int          results_seen;
	int          cycles;

	task automatic flag_mismatch(string note);
		$display("[%0t] result %0d: %s", $realtime, results_seen, note);
		mismatches++;
	endtask

	function automatic result_t assign_pillar(lidar_word_t w);
		result_t r;
		longint  prod_x, prod_y, col, row, flat;
		bit      hit;
		r = '0;
		if (w.kind == KIND_FRAME) begin
			pillar_of_cell.delete();
			pillars_opened = '0;
			return r;
		end
		prod_x = (longint'(w.x) - longint'(org_x)) * longint'(recip_x);
		prod_y = (longint'(w.y) - longint'(org_y)) * longint'(recip_y);
		col = prod_x >>> FRAC_W;
		row = prod_y >>> FRAC_W;
		hit = prod_x >= 0 && prod_y >= 0 && col < longint'(grid_cols) &&
			row < longint'(grid_rows) && w.z >= z_floor && w.z < z_lim;
		flat = 0;
		if (hit) begin
			flat = row * longint'(grid_cols) + col;
			hit = flat < longint'(MAP_DEPTH);
		end
		if (hit) begin
			r.in_range = 1'b1;
			r.cell_index = IDX_OUT_W'(flat);
			if (pillar_of_cell.exists(int'(flat))) begin
				r.pillar_index = pillar_of_cell[int'(flat)];
			end else if (pillars_opened < COUNT_MAX) begin
				pillar_of_cell[int'(flat)] = PILLAR_W'(pillars_opened);
				r.pillar_index = PILLAR_W'(pillars_opened);
				r.is_new = 1'b1;
				pillars_opened = pillars_opened + 1'b1;
			end
		end
		r.pillar_count = pillars_opened;
		return r;
	endfunction

	// point channel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_ch.valid <= 1'b0;
		end else begin
			if (pts_ch.valid && pts_ch.ready)
				pillar_results_due.push_back(assign_pillar(on_wire));
			if (!pts_ch.valid || pts_ch.ready) begin
				if (send_hold > 0) begin
					send_hold--;
					pts_ch.valid <= 1'b0;
				end else if (point_words.size() != 0 && !steady && $urandom_range(0, 7) == 0) begin
					send_hold = $urandom_range(0, 9);
					pts_ch.valid <= 1'b0;
				end else if (point_words.size() != 0) begin
					on_wire = point_words.pop_front();
					pts_ch.valid   <= 1'b1;
					pts_ch.kind    <= on_wire.kind;
					pts_ch.point_x <= on_wire.x;
					pts_ch.point_y <= on_wire.y;
					pts_ch.point_z <= on_wire.z;
				end else begin
					pts_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result channel monitor and checker
	always @(posedge clk or negedge arst_n) begin : watch_results
		result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pillar_results_due.size() == 0) begin
					flag_mismatch("result word with nothing expected");
				end else begin
					want = pillar_results_due.pop_front();
					if (res_ch.in_range !== want.in_range)
						flag_mismatch($sformatf("in_range %0b, want %0b",
							res_ch.in_range, want.in_range));
					if (res_ch.is_new !== want.is_new)
						flag_mismatch($sformatf("is_new %0b, want %0b",
							res_ch.is_new, want.is_new));
					if (res_ch.cell_index !== want.cell_index)
						flag_mismatch($sformatf("cell_index %0d, want %0d",
							res_ch.cell_index, want.cell_index));
					if (res_ch.pillar_index !== want.pillar_index)
						flag_mismatch($sformatf("pillar_index %0d, want %0d",
							res_ch.pillar_index, want.pillar_index));
					if (res_ch.pillar_count !== want.pillar_count)
						flag_mismatch($sformatf("pillar_count %0d, want %0d",
							res_ch.pillar_count, want.pillar_count));
				end
				results_seen++;
			end
			if (steady) begin
				res_ch.ready <= 1'b1;
			end else if (recv_hold > 0) begin
				recv_hold--;
				res_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				recv_hold = $urandom_range(0, 9);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("point_to_pillar_index_assign_unit: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_MIN_X:        org_x = data[COORD_W-1:0];
			REG_MIN_Y:        org_y = data[COORD_W-1:0];
			REG_MIN_Z:        z_floor = data[COORD_W-1:0];
			REG_Z_LIMIT:      z_lim = data[COORD_W-1:0];
			REG_INV_SIZE_X:   recip_x = data[INV_W-1:0];
			REG_INV_SIZE_Y:   recip_y = data[INV_W-1:0];
			REG_GRID_COLUMNS: grid_cols = data[GRID_W-1:0];
			REG_GRID_ROWS:    grid_rows = data[GRID_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [CFG_DATA_W-1:0] widen(int v);
		logic signed [COORD_W-1:0] c;
		c = COORD_W'(v);
		return {{(CFG_DATA_W - COORD_W){c[COORD_W-1]}}, c};
	endfunction

	task automatic set_grid(int mx, int my, int mz, int zl, int ix, int iy, int nc, int nr);
		write_reg(REG_MIN_X, widen(mx));
		write_reg(REG_MIN_Y, widen(my));
		write_reg(REG_MIN_Z, widen(mz));
		write_reg(REG_Z_LIMIT, widen(zl));
		write_reg(REG_INV_SIZE_X, CFG_DATA_W'(ix));
		write_reg(REG_INV_SIZE_Y, CFG_DATA_W'(iy));
		write_reg(REG_GRID_COLUMNS, CFG_DATA_W'(GRID_W'(nc)));
		write_reg(REG_GRID_ROWS, CFG_DATA_W'(GRID_W'(nr)));
	endtask

	task automatic queue_point(int x, int y, int z);
		lidar_word_t w;
		w.kind = KIND_POINT;
		w.x = COORD_W'(x);
		w.y = COORD_W'(y);
		w.z = COORD_W'(z);
		point_words.push_back(w);
	endtask

	task automatic queue_frame();
		lidar_word_t w;
		w.kind = KIND_FRAME;
		w.x = COORD_W'($urandom);
		w.y = COORD_W'($urandom);
		w.z = COORD_W'($urandom);
		point_words.push_back(w);
	endtask

	// coordinate that lands near the given cell, cell edges included
	function automatic int aim_coord(logic signed [COORD_W-1:0] org, logic [INV_W-1:0] recip,
			int slot);
		longint lead, c;
		if (recip == 0)
			return int'(COORD_W'($urandom)) - (1 << (COORD_W - 1));
		case ($urandom_range(0, 3))
			0: lead = 0;
			1: lead = (longint'(1) << FRAC_W) - 1;
			default: lead = longint'($urandom_range(0, (1 << FRAC_W) - 1));
		endcase
		c = longint'(org) + ((longint'(slot) <<< FRAC_W) + lead) / longint'(recip);
		if (c > COORD_MAX)
			c = COORD_MAX;
		else if (c < COORD_MIN)
			c = COORD_MIN;
		return int'(c);
	endfunction

	function automatic int pick_cell(int n, int span);
		int lim;
		if (n <= 0)
			return $urandom_range(0, 3);
		lim = (n < span) ? n : span;
		case ($urandom_range(0, 15))
			0: return -1;
			1: return n;
			2: return n - 1;
			3: return int'($urandom_range(0, n - 1));
			default: return int'($urandom_range(0, lim - 1));
		endcase
	endfunction

	function automatic int pick_height();
		int lo, hi;
		lo = z_floor;
		hi = z_lim;
		if (hi <= lo || $urandom_range(0, 9) == 0)
			return int'($urandom);
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi - 1;
			2: return hi;
			3: return lo - 1;
			default: return lo + int'($urandom_range(0, hi - lo - 1));
		endcase
	endfunction

	task automatic queue_scan_point(int span);
		if ($urandom_range(0, 9) == 0)
			queue_point($urandom, $urandom, $urandom);
		else
			queue_point(aim_coord(org_x, recip_x, pick_cell(int'(grid_cols), span)),
				aim_coord(org_y, recip_y, pick_cell(int'(grid_rows), span)),
				pick_height());
	endtask

	task automatic run_phase(int n, int span, int frame_odds);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, frame_odds - 1) == 0)
				queue_frame();
			else
				queue_scan_point(span);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (point_words.size() != 0 || pts_ch.valid || pillar_results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		pts_ch.valid = 1'b0;
		pts_ch.kind = KIND_POINT;
		pts_ch.point_x = '0;
		pts_ch.point_y = '0;
		pts_ch.point_z = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		org_x = '0;
		org_y = '0;
		z_floor = '0;
		z_lim = '0;
		recip_x = INV_W'(65536);
		recip_y = INV_W'(65536);
		grid_cols = GRID_W'(200);
		grid_rows = GRID_W'(200);
		pillars_opened = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 1 m cells, 200 x 200, z window [-3 m, 1 m)
		set_grid(0, 0, -768, 256, 65536, 65536, 200, 200);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		queue_frame();
		queue_point(0, 0, 0);
		queue_point(0, 0, 0);
		queue_point(51199, 51199, 255);
		queue_point(51200, 0, 0);
		queue_point(-1, 0, 0);
		queue_point(0, -1, 0);
		queue_point(0, 0, -768);
		queue_point(0, 0, 256);
		queue_point(0, 0, 255);
		queue_point(524287, 524287, 524287);
		queue_point(-524288, -524288, -524288);
		queue_point(1408, 1792, -1);
		queue_frame();
		queue_point(0, 0, 0);
		queue_point(1280, 1792, 0);
		queue_point(256, 0, 0);
		wait_drained();

		// register extremes: widest reciprocal, zero reciprocal, oversized grid
		set_grid(-524288, 524287, -524288, 524287, 16777215, 0, 2047, 2047);
		queue_point(-524288, 524287, -524288);
		queue_point(524287, -524288, 524286);
		queue_point(-522241, 0, 0);
		run_phase(15, 40, 15);
		wait_drained();

		// empty grid in one direction, then the other
		set_grid(0, 0, -256, 256, 65536, 65536, 0, 5);
		run_phase(6, 8, 10);
		wait_drained();
		set_grid(0, 0, -256, 256, 65536, 65536, 5, 0);
		run_phase(6, 8, 10);
		wait_drained();

		// cells past the end of the map
		set_grid(0, 0, -1024, 1024, 65536, 65536, 1024, 1024);
		queue_point(1023 * 256, 1023 * 256, 0);
		queue_point(1023 * 256, 63 * 256, 0);
		run_phase(15, 128, 20);
		wait_drained();

		// zero reciprocal in x: every x maps to column 0
		set_grid(300, -2560, -512, 2048, 0, 32768, 7, 50);
		run_phase(12, 12, 12);
		wait_drained();

		// many short frames so the per-entry frame tag wraps around
		set_grid(-256, -256, -512, 512, 131072, 131072, 4, 3);
		for (int f = 0; f < 258; f++) begin
			queue_frame();
			if (f >= 240 || $urandom_range(0, 4) == 0)
				queue_scan_point(4);
		end
		wait_drained();

		for (int k = 0; k < 3; k++) begin
			set_grid(int'($urandom_range(0, 102400)) - 51200,
				int'($urandom_range(0, 102400)) - 51200,
				int'($urandom_range(0, 4096)) - 2048,
				int'($urandom_range(0, 8192)) - 2048,
				$urandom_range(8192, 262144), $urandom_range(8192, 262144),
				$urandom_range(1, 300), $urandom_range(1, 300));
			run_phase(12, 16, 20);
			wait_drained();
		end

		// closing stretch with both sides streaming
		set_grid(-25600, -12800, -768, 512, 65536, 98304, 200, 160);
		steady = 1'b1;
		run_phase(30, 20, 25);
		wait_drained();

		if (mismatches == 0)
			$display("point_to_pillar_index_assign_unit: match");
		else
			$display("point_to_pillar_index_assign_unit: mismatch");
		$finish;
	end

endmodule

### files.f
rtl/core/ppia_pkg.sv
rtl/core/ppia_if.sv
rtl/core/ppia_cell_calc.sv
rtl/core/point_to_pillar_index_assign_unit.sv
tb/sv/tb_top.sv
